FILE: rtl/pet_pkg.sv
// ----------------------------------------------------------------------------
// pet_pkg
// Shared codes for the polygon edge table builder: result status and
// winding encodings, and the width of the peak count.
// ----------------------------------------------------------------------------
`default_nettype none

package pet_pkg;

	localparam int PEAK_W = 7;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	localparam logic signed [1:0] WIND_DOWN = 2'sb01;
	localparam logic signed [1:0] WIND_UP   = 2'sb11;

endpackage

`default_nettype wire

FILE: rtl/pet_ram.sv
// ----------------------------------------------------------------------------
// pet_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pet_ram #(
	parameter int AW = 5,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/polygon_edge_table_setup.sv
// ----------------------------------------------------------------------------
// polygon_edge_table_setup
// Builds a sorted edge table for one polygon from a stream of vertices.
// ----------------------------------------------------------------------------
// Input beats carry one vertex each; last_point closes the ring. Vertices
// are taken one per cycle while in_ready is high. After the last vertex,
// in_ready stays low until every result beat of the polygon is taken.
// Each vertex is read back in a ring walk (S_BRD, S_BGET); each kept edge
// is placed by a stable insertion into the edge memory (S_IRD, S_ICMP).
// The peak sweep reads the edge memory once per edge and rescans the
// prefix at each distinct top row. Results then leave one beat at a time
// through S_ERD, S_EGET and S_EWAIT; a stalled receiver simply holds the
// output register.
// An error polygon gives one beat with final_edge set.
// Reset clears the control state; the memories need no clearing, as every
// entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_edge_table_setup
	import pet_pkg::*;
#(
	parameter int MAX_VERTICES = 32,
	parameter int COORD_BITS   = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] point_x,
	input  wire logic signed [COORD_BITS-1:0] point_y,
	input  wire logic                         last_point,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [COORD_BITS-1:0]      top_x,
	output logic signed [COORD_BITS-1:0]      top_y,
	output logic signed [COORD_BITS-1:0]      bottom_x,
	output logic signed [COORD_BITS-1:0]      bottom_y,
	output logic signed [1:0]                 winding,
	output logic signed [COORD_BITS-1:0]      box_left,
	output logic signed [COORD_BITS-1:0]      box_top,
	output logic        [COORD_BITS-1:0]      box_width,
	output logic        [COORD_BITS-1:0]      box_height,
	output logic        [PEAK_W-1:0]          peak_active,
	output logic        [1:0]                 status,
	output logic                              final_edge
);

	localparam int CB   = COORD_BITS;
	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int VC_W = $clog2(MAX_VERTICES + 1);
	localparam int VW   = 2 * CB;
	localparam int EW   = 4 * CB + 1;

	localparam logic [VC_W-1:0] MAX_CNT = VC_W'(MAX_VERTICES);
	localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

	localparam logic [4:0] S_IN    = 5'd0;
	localparam logic [4:0] S_B0    = 5'd1;
	localparam logic [4:0] S_B1    = 5'd2;
	localparam logic [4:0] S_BRD   = 5'd3;
	localparam logic [4:0] S_BGET  = 5'd4;
	localparam logic [4:0] S_IRD   = 5'd5;
	localparam logic [4:0] S_ICMP  = 5'd6;
	localparam logic [4:0] S_CHK   = 5'd7;
	localparam logic [4:0] S_GRD   = 5'd8;
	localparam logic [4:0] S_GGET  = 5'd9;
	localparam logic [4:0] S_GN    = 5'd10;
	localparam logic [4:0] S_GNG   = 5'd11;
	localparam logic [4:0] S_SRD   = 5'd12;
	localparam logic [4:0] S_SGET  = 5'd13;
	localparam logic [4:0] S_ERD   = 5'd14;
	localparam logic [4:0] S_EGET  = 5'd15;
	localparam logic [4:0] S_EWAIT = 5'd16;
	localparam logic [4:0] S_ERR   = 5'd17;

	logic [4:0]            state_q;
	logic [VC_W-1:0]       vcnt_q, ridx_q, n_q, cnt_q;
	logic                  ovf_q, closing_q, last_q;
	logic [1:0]            err_q;
	logic [AW-1:0]         i_q, j_q;
	logic [VW-1:0]         first_q, prev_q;
	logic [EW-1:0]         e_q;
	logic signed [CB-1:0]  xmin_q, xmax_q, ymin_q, ymax_q, row_q;
	logic [PEAK_W-1:0]     peak_q;

	logic                  v_we;
	logic [AW-1:0]         v_raddr;
	logic [VW-1:0]         v_rdata;
	logic                  e_we;
	logic [AW-1:0]         e_waddr, e_raddr;
	logic [EW-1:0]         e_wdata, e_rdata;

	pet_ram #(.AW(AW), .DW(VW)) u_vtx_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (vcnt_q[AW-1:0]),
		.wdata ({point_x, point_y}),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	pet_ram #(.AW(AW), .DW(EW)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	logic                 in_acc, out_acc;
	logic [VW-1:0]        cur_v;
	logic signed [CB-1:0] px, py, cx, cy;
	logic [EW-1:0]        new_e;
	logic signed [CB-1:0] ne_tx, ne_ty, ne_bx, ne_by;
	logic signed [CB-1:0] ke_tx, ke_ty, md_tx, md_ty, md_by;
	logic                 e_first;
	logic [VC_W-1:0]      i_inc, cnt_new;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign in_ready = (state_q == S_IN);

	assign cur_v = (state_q == S_BGET) ? v_rdata : first_q;
	assign px = $signed(prev_q[VW-1:CB]);
	assign py = $signed(prev_q[CB-1:0]);
	assign cx = $signed(cur_v[VW-1:CB]);
	assign cy = $signed(cur_v[CB-1:0]);
	assign new_e = (py < cy) ? {px, py, cx, cy, 1'b0} : {cx, cy, px, py, 1'b1};
	assign ne_tx = $signed(new_e[4*CB:3*CB+1]);
	assign ne_ty = $signed(new_e[3*CB:2*CB+1]);
	assign ne_bx = $signed(new_e[2*CB:CB+1]);
	assign ne_by = $signed(new_e[CB:1]);

	assign ke_tx = $signed(e_q[4*CB:3*CB+1]);
	assign ke_ty = $signed(e_q[3*CB:2*CB+1]);
	assign md_tx = $signed(e_rdata[4*CB:3*CB+1]);
	assign md_ty = $signed(e_rdata[3*CB:2*CB+1]);
	assign md_by = $signed(e_rdata[CB:1]);
	assign e_first = (ke_ty < md_ty) || ((ke_ty == md_ty) && (ke_tx < md_tx));

	assign i_inc   = VC_W'(i_q) + VC_W'(1);
	assign cnt_new = cnt_q + ((md_by > row_q) ? VC_W'(1) : VC_W'(0));

	assign v_we    = in_acc && (vcnt_q < MAX_CNT);
	assign v_raddr = (state_q == S_B0) ? AW'(0) : ridx_q[AW-1:0];

	always_comb begin
		e_we    = 1'b0;
		e_waddr = j_q;
		e_wdata = e_q;
		e_raddr = i_q;
		unique case (state_q)
			S_IRD: begin
				e_raddr = j_q - AW'(1);
				if (j_q == AW'(0)) begin
					e_we = 1'b1;
				end
			end
			S_ICMP: begin
				e_we = 1'b1;
				if (e_first) begin
					e_wdata = e_rdata;
				end
			end
			S_GN:    e_raddr = i_inc[AW-1:0];
			S_SRD:   e_raddr = j_q;
			default: e_raddr = i_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IN;
			vcnt_q    <= '0;
			n_q       <= '0;
			ovf_q     <= 1'b0;
			closing_q <= 1'b0;
			out_valid <= 1'b0;
			xmin_q    <= C_MAX;
			ymin_q    <= C_MAX;
			xmax_q    <= C_MIN;
			ymax_q    <= C_MIN;
		end else begin
			unique case (state_q)
				S_IN: begin
					if (in_acc) begin
						if (vcnt_q < MAX_CNT) begin
							vcnt_q <= vcnt_q + VC_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_point) begin
							if (ovf_q || (vcnt_q == MAX_CNT)) begin
								err_q   <= ST_OVF;
								state_q <= S_ERR;
							end else begin
								state_q <= S_B0;
							end
						end
					end
				end
				S_B0: state_q <= S_B1;
				S_B1: begin
					first_q   <= v_rdata;
					prev_q    <= v_rdata;
					ridx_q    <= VC_W'(1);
					closing_q <= 1'b0;
					state_q   <= S_BRD;
				end
				S_BRD, S_BGET: begin
					if (state_q == S_BRD && ridx_q < vcnt_q) begin
						state_q <= S_BGET;
					end else begin
						if (state_q == S_BGET) begin
							prev_q <= v_rdata;
							ridx_q <= ridx_q + VC_W'(1);
						end else begin
							closing_q <= 1'b1;
						end
						if (py == cy) begin
							state_q <= (state_q == S_BRD) ? S_CHK : S_BRD;
						end else begin
							e_q <= new_e;
							j_q <= n_q[AW-1:0];
							if (ne_ty < ymin_q) ymin_q <= ne_ty;
							if (ne_by > ymax_q) ymax_q <= ne_by;
							if (ne_tx < xmin_q && ne_tx <= ne_bx) xmin_q <= ne_tx;
							else if (ne_bx < xmin_q) xmin_q <= ne_bx;
							if (ne_tx > xmax_q && ne_tx >= ne_bx) xmax_q <= ne_tx;
							else if (ne_bx > xmax_q) xmax_q <= ne_bx;
							state_q <= S_IRD;
						end
					end
				end
				S_IRD: begin
					if (j_q == AW'(0)) begin
						n_q     <= n_q + VC_W'(1);
						state_q <= closing_q ? S_CHK : S_BRD;
					end else begin
						state_q <= S_ICMP;
					end
				end
				S_ICMP: begin
					if (e_first) begin
						j_q     <= j_q - AW'(1);
						state_q <= S_IRD;
					end else begin
						n_q     <= n_q + VC_W'(1);
						state_q <= closing_q ? S_CHK : S_BRD;
					end
				end
				S_CHK: begin
					if (n_q < VC_W'(2)) begin
						err_q   <= ST_FEW;
						state_q <= S_ERR;
					end else begin
						peak_q  <= PEAK_W'(2);
						i_q     <= '0;
						state_q <= S_GRD;
					end
				end
				S_GRD: state_q <= S_GGET;
				S_GGET: begin
					row_q   <= md_ty;
					state_q <= S_GN;
				end
				S_GN: begin
					if (i_inc < n_q) begin
						state_q <= S_GNG;
					end else begin
						j_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_SRD;
					end
				end
				S_GNG: begin
					if (md_ty == row_q) begin
						i_q     <= i_inc[AW-1:0];
						state_q <= S_GN;
					end else begin
						j_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SGET;
				S_SGET: begin
					cnt_q <= cnt_new;
					if (j_q == i_q) begin
						if (PEAK_W'(cnt_new) > peak_q) begin
							peak_q <= PEAK_W'(cnt_new);
						end
						if (i_inc < n_q) begin
							i_q     <= i_inc[AW-1:0];
							state_q <= S_GRD;
						end else begin
							i_q     <= '0;
							state_q <= S_ERD;
						end
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= S_SRD;
					end
				end
				S_ERD: state_q <= S_EGET;
				S_EGET: begin
					top_x       <= md_tx;
					top_y       <= md_ty;
					bottom_x    <= $signed(e_rdata[2*CB:CB+1]);
					bottom_y    <= md_by;
					winding     <= e_rdata[0] ? WIND_UP : WIND_DOWN;
					box_left    <= xmin_q;
					box_top     <= ymin_q;
					box_width   <= xmax_q - xmin_q;
					box_height  <= ymax_q - ymin_q;
					peak_active <= peak_q;
					status      <= ST_OK;
					final_edge  <= (i_inc == n_q);
					last_q      <= (i_inc == n_q);
					out_valid   <= 1'b1;
					state_q     <= S_EWAIT;
				end
				S_ERR: begin
					top_x       <= '0;
					top_y       <= '0;
					bottom_x    <= '0;
					bottom_y    <= '0;
					winding     <= '0;
					box_left    <= '0;
					box_top     <= '0;
					box_width   <= '0;
					box_height  <= '0;
					peak_active <= '0;
					status      <= err_q;
					final_edge  <= 1'b1;
					last_q      <= 1'b1;
					out_valid   <= 1'b1;
					state_q     <= S_EWAIT;
				end
				S_EWAIT: begin
					if (out_acc) begin
						out_valid <= 1'b0;
						if (last_q) begin
							vcnt_q  <= '0;
							n_q     <= '0;
							ovf_q   <= 1'b0;
							xmin_q  <= C_MAX;
							ymin_q  <= C_MAX;
							xmax_q  <= C_MIN;
							ymax_q  <= C_MIN;
							state_q <= S_IN;
						end else begin
							i_q     <= i_inc[AW-1:0];
							state_q <= S_ERD;
						end
					end
				end
				default: state_q <= S_IN;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_edges_le_vertices: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= vcnt_q)
		else $error("edge count exceeds vertex count");

	a_error_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> final_edge)
		else $error("error result without final mark");

	a_ready_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && final_edge) |=> in_ready)
		else $error("block not ready after last result");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Polygon edge table builder testbench
// Streams polygons of random vertices into the block and checks every result
// beat against a behavioral edge table model: ring closing, orientation,
// stable sort, bounding box, peak active count and the error results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import pet_pkg::*;

	localparam int MAXV = 32;
	localparam int LIMIT = 3000000;

	typedef struct packed {
		logic signed [15:0] tx, ty, bx, by;
		logic signed [1:0]  wind;
		logic signed [15:0] left, top;
		logic        [15:0] width, height;
		logic        [6:0]  peak;
		logic        [1:0]  st;
		logic               fin;
	} edge_beat_t;

	class edge_scoreboard;
		edge_beat_t pending[$];
		int signed vx[MAXV];
		int signed vy[MAXV];
		int nverts;
		bit ovf;
		int errors;

		function void push_error(logic [1:0] code);
			edge_beat_t b;
			b = '{default: 0};
			b.st = code;
			b.fin = 1'b1;
			pending.push_back(b);
		endfunction

		function void note_vertex(logic signed [15:0] x, logic signed [15:0] y, bit last);
			edge_beat_t list[$];
			edge_beat_t e;
			int signed fx, fy, gx, gy, xmin, xmax, ymin, ymax, row;
			int n, i, j, k, cnt, peak;
			bit act[MAXV];
			if (nverts < MAXV) begin
				vx[nverts] = x;
				vy[nverts] = y;
				nverts++;
			end else
				ovf = 1;
			if (!last)
				return;
			if (ovf) begin
				push_error(ST_OVF);
				nverts = 0;
				ovf = 0;
				return;
			end
			xmin = 32767; ymin = 32767; xmax = -32768; ymax = -32768;
			for (i = 0; i < nverts; i++) begin
				k = (i + 1 >= nverts) ? 0 : i + 1;
				fx = vx[i]; fy = vy[i]; gx = vx[k]; gy = vy[k];
				if (fy == gy)
					continue;
				e = '{default: 0};
				if (fy < gy) begin
					e.wind = WIND_DOWN; e.tx = fx; e.ty = fy; e.bx = gx; e.by = gy;
				end else begin
					e.wind = WIND_UP; e.tx = gx; e.ty = gy; e.bx = fx; e.by = fy;
				end
				if (e.ty < ymin) ymin = e.ty;
				if (e.by > ymax) ymax = e.by;
				if (e.tx < xmin) xmin = e.tx;
				if (e.tx > xmax) xmax = e.tx;
				if (e.bx < xmin) xmin = e.bx;
				if (e.bx > xmax) xmax = e.bx;
				j = list.size();
				while (j > 0 && (e.ty < list[j-1].ty ||
						(e.ty == list[j-1].ty && e.tx < list[j-1].tx)))
					j--;
				list.insert(j, e);
			end
			nverts = 0;
			n = list.size();
			if (n < 2) begin
				push_error(ST_FEW);
				return;
			end
			peak = 2;
			for (i = 0; i < MAXV; i++)
				act[i] = 0;
			i = 0;
			while (i < n) begin
				row = list[i].ty;
				for (j = 0; j < n; j++)
					if (act[j] && row >= list[j].by)
						act[j] = 0;
				do begin
					act[i] = 1;
					i++;
				end while (i < n && list[i].ty == row);
				cnt = 0;
				for (j = 0; j < n; j++)
					cnt += act[j];
				if (cnt > peak)
					peak = cnt;
			end
			for (i = 0; i < n; i++) begin
				e = list[i];
				e.left = xmin;
				e.top = ymin;
				e.width = xmax - xmin;
				e.height = ymax - ymin;
				e.peak = peak;
				e.st = ST_OK;
				e.fin = (i == n - 1);
				pending.push_back(e);
			end
		endfunction

		function void check_beat(edge_beat_t got);
			edge_beat_t exp_b;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat at %0t", $realtime);
				return;
			end
			exp_b = pending.pop_front();
			if (got !== exp_b) begin
				errors++;
				if (errors <= 10)
					$display("mismatch at %0t: expected %p got %p", $realtime, exp_b, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] point_x = 0, point_y = 0;
	logic last_point = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] top_x, top_y, bottom_x, bottom_y, box_left, box_top;
	logic signed [1:0] winding;
	logic [15:0] box_width, box_height;
	logic [6:0] peak_active;
	logic [1:0] status;
	logic final_edge;

	edge_scoreboard sb = new();
	int cycles = 0;
	bit hold_off = 0;
	bit long_hold_done = 0;

	always #6 clk = ~clk;

	polygon_edge_table_setup uut (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (in_valid && in_ready)
			sb.note_vertex(point_x, point_y, last_point);
		if (out_valid && out_ready)
			sb.check_beat('{top_x, top_y, bottom_x, bottom_y, winding, box_left, box_top,
				box_width, box_height, peak_active, status, final_edge});
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (arst_n && !hold_off)
			out_ready <= ($urandom_range(0, 3) != 0);
		else
			out_ready <= 0;
	end

	initial begin
		wait (long_hold_done == 0);
		@(posedge in_valid);
		repeat (60) @(negedge clk);
		hold_off <= 1;
		repeat (400) @(negedge clk);
		hold_off <= 0;
		long_hold_done <= 1;
	end

	task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit last,
			bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		point_x <= x;
		point_y <= y;
		last_point <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_polygon(int n, int span);
		int i;
		for (i = 0; i < n; i++)
			send_vertex($urandom_range(0, span) - span / 2,
				$urandom_range(0, span) - span / 2, i == n - 1, 1);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
	endtask

	int sent;

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Directed: extremes, one vertex, horizontal-only, ties, overflow.
		send_vertex(16'sh7fff, 16'sh8000, 0, 0);
		send_vertex(16'sh8000, 16'sh7fff, 0, 0);
		send_vertex(16'sh7fff, 16'sh7fff, 1, 0);
		send_vertex(5, 5, 1, 0);
		send_vertex(1, 3, 0, 0);
		send_vertex(9, 3, 1, 0);
		send_vertex(0, 0, 0, 0);
		send_vertex(4, 0, 0, 0);
		send_vertex(4, 4, 0, 0);
		send_vertex(0, 4, 1, 0);
		send_vertex(0, 0, 0, 0);
		send_vertex(-1, 8, 0, 0);
		send_vertex(0, 0, 0, 0);
		send_vertex(1, 8, 1, 0);
		drain();
		repeat (MAXV + 2)
			send_vertex($urandom, $urandom, 0, 0);
		send_vertex(0, 0, 1, 0);
		drain();
		sent = 0;
		while (sent < 130) begin
			int n, r;
			r = $urandom_range(0, 19);
			if (r == 0) n = MAXV;
			else if (r == 1) n = $urandom_range(1, 2);
			else n = $urandom_range(3, 10);
			if ($urandom_range(0, 4) == 0)
				for (int i = 0; i < n; i++)
					send_vertex($urandom, $urandom, i == n - 1, 1);
			else
				send_polygon(n, $urandom_range(0, 1) ? 8 : 200);
			sent += n;
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		drain();
		repeat (200) @(negedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk)
		if (out_valid && out_ready && sb.pending.size() == 0 && !arst_n)
			sb.errors++;
endmodule
